[sv/bps_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bps_pkg
// Shared constants for the buzzer pattern sequencer: tones, sources, register
// indexes, register reset values and pattern phases.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 11;

  typedef logic [CfgIndexWidth-1:0] cfg_index_t;
  typedef logic [CfgDataWidth-1:0]  cfg_data_t;
  typedef logic [1:0]               tone_t;
  typedef logic [2:0]               source_t;
  typedef logic [2:0]               phase_t;

  localparam tone_t TONE_BASE = 2'd0;
  localparam tone_t TONE_MID  = 2'd1;
  localparam tone_t TONE_LOW  = 2'd2;

  localparam source_t SRC_NONE    = 3'd0;
  localparam source_t SRC_KEY     = 3'd1;
  localparam source_t SRC_CONFIRM = 3'd2;
  localparam source_t SRC_BATTERY = 3'd3;
  localparam source_t SRC_NOTICE  = 3'd4;

  localparam cfg_index_t REG_KEY_BEEP_LIMIT     = 3'd0;
  localparam cfg_index_t REG_CONFIRM_BEEP_LIMIT = 3'd1;
  localparam cfg_index_t REG_ALARM_ON_TICKS     = 3'd2;
  localparam cfg_index_t REG_ALARM_OFF_TICKS    = 3'd3;
  localparam cfg_index_t REG_ALARM_PAUSE_LIMIT  = 3'd4;
  localparam cfg_index_t REG_NOTICE_TICKS       = 3'd5;

  localparam logic [7:0]  KEY_BEEP_LIMIT_RESET     = 8'd2;
  localparam logic [7:0]  CONFIRM_BEEP_LIMIT_RESET = 8'd100;
  localparam logic [10:0] ALARM_ON_TICKS_RESET     = 11'd80;
  localparam logic [10:0] ALARM_OFF_TICKS_RESET    = 11'd200;
  localparam logic [10:0] ALARM_PAUSE_LIMIT_RESET  = 11'd1410;
  localparam logic [7:0]  NOTICE_TICKS_RESET       = 8'd100;

  localparam phase_t ALARM_PHASE_IDLE  = 3'd0;
  localparam phase_t ALARM_PHASE_GAP_A = 3'd2;
  localparam phase_t ALARM_PHASE_GAP_B = 3'd4;
  localparam phase_t ALARM_PHASE_PAUSE = 3'd7;

  localparam phase_t NOTICE_PHASE_IDLE = 3'd0;
  localparam phase_t NOTICE_PHASE_LAST = 3'd5;

endpackage

`default_nettype wire

[sv/buzzer_pattern_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer
// Serves one tick per beat: latches request pulses, runs the highest-priority
// beep pattern and reports buzzer drive, tone and served source.
// ----------------------------------------------------------------------------
//  channel | signals                                         | direction
//  tick    | in_valid, in_stall, key_beep_request,           | in
//          | confirm_request, low_battery_alarm,             |
//          | all_closed_request                              |
//  result  | out_valid, out_stall, buzzer_on, tone_select,   | out
//          | active_source                                   |
//  config  | cfg_write, cfg_index, cfg_data                  | in
//
//  A tick beat lands in an input register, is served from there and its
//  result is captured in the output register; one beat per cycle is
//  sustained while the result is not stalled.
//  Reset clears all sequence state and restores the register defaults.
//  A stalled result holds both stages once the input register is full; the
//  input stage takes a beat while empty or while the output is free or emptied.
// ----------------------------------------------------------------------------
module buzzer_pattern_sequencer (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire bps_pkg::cfg_index_t   cfg_index,
  input  wire bps_pkg::cfg_data_t    cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  key_beep_request,
  input  wire logic                  confirm_request,
  input  wire logic                  low_battery_alarm,
  input  wire logic                  all_closed_request,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       buzzer_on,
  output bps_pkg::tone_t             tone_select,
  output bps_pkg::source_t           active_source
);
  import bps_pkg::*;

  logic [7:0]  key_beep_limit;
  logic [7:0]  confirm_beep_limit;
  logic [10:0] alarm_on_ticks;
  logic [10:0] alarm_off_ticks;
  logic [10:0] alarm_pause_limit;
  logic [7:0]  notice_ticks;

  logic tick_valid;
  logic tick_key;
  logic tick_confirm;
  logic tick_battery;
  logic tick_notice;
  logic advance;

  logic        key_pending,     key_pending_next;
  logic        confirm_pending, confirm_pending_next;
  logic        notice_pending,  notice_pending_next;
  logic [7:0]  beep_timer,      beep_timer_next;
  phase_t      alarm_phase,     alarm_phase_next;
  logic [10:0] alarm_timer,     alarm_timer_next;
  phase_t      notice_phase,    notice_phase_next;
  logic [7:0]  notice_timer,    notice_timer_next;
  logic        drive_on,        drive_on_next;
  tone_t       tone_reg,        tone_reg_next;
  source_t     source_next;

  logic        key_now, confirm_now, notice_now;
  logic [8:0]  beep_count;
  logic [7:0]  beep_limit;
  logic [11:0] alarm_count;
  logic        alarm_done;
  logic [8:0]  notice_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_beep_limit     <= KEY_BEEP_LIMIT_RESET;
      confirm_beep_limit <= CONFIRM_BEEP_LIMIT_RESET;
      alarm_on_ticks     <= ALARM_ON_TICKS_RESET;
      alarm_off_ticks    <= ALARM_OFF_TICKS_RESET;
      alarm_pause_limit  <= ALARM_PAUSE_LIMIT_RESET;
      notice_ticks       <= NOTICE_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEY_BEEP_LIMIT:     key_beep_limit     <= cfg_data[7:0];
        REG_CONFIRM_BEEP_LIMIT: confirm_beep_limit <= cfg_data[7:0];
        REG_ALARM_ON_TICKS:     alarm_on_ticks     <= cfg_data;
        REG_ALARM_OFF_TICKS:    alarm_off_ticks    <= cfg_data;
        REG_ALARM_PAUSE_LIMIT:  alarm_pause_limit  <= cfg_data;
        REG_NOTICE_TICKS:       notice_ticks       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign advance  = tick_valid && (!out_valid || !out_stall);
  assign in_stall = tick_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      tick_valid <= 1'b1;
    end else if (advance) begin
      tick_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      tick_key     <= key_beep_request;
      tick_confirm <= confirm_request;
      tick_battery <= low_battery_alarm;
      tick_notice  <= all_closed_request;
    end
  end

  assign key_now     = key_pending || tick_key;
  assign confirm_now = confirm_pending || tick_confirm;
  assign notice_now  = notice_pending || tick_notice;
  assign beep_limit  = key_now ? key_beep_limit : confirm_beep_limit;
  assign beep_count  = {1'b0, beep_timer} + 9'd1;
  assign alarm_count = {1'b0, alarm_timer} + 12'd1;
  assign notice_count = {1'b0, notice_timer} + 9'd1;

  always_comb begin
    if (alarm_phase == ALARM_PHASE_PAUSE) begin
      alarm_done = alarm_count > {1'b0, alarm_pause_limit};
    end else if (alarm_phase[0]) begin
      alarm_done = alarm_count >= {1'b0, alarm_on_ticks};
    end else begin
      alarm_done = alarm_count >= {1'b0, alarm_off_ticks};
    end
  end

  always_comb begin
    key_pending_next     = key_now;
    confirm_pending_next = confirm_now;
    notice_pending_next  = notice_now;
    beep_timer_next      = beep_timer;
    alarm_phase_next     = alarm_phase;
    alarm_timer_next     = alarm_timer;
    notice_phase_next    = notice_phase;
    notice_timer_next    = notice_timer;
    drive_on_next        = drive_on;
    tone_reg_next        = tone_reg;
    source_next          = SRC_NONE;

    priority if (key_now || confirm_now) begin
      source_next = key_now ? SRC_KEY : SRC_CONFIRM;
      if (beep_timer == 8'd0) begin
        drive_on_next = 1'b1;
        tone_reg_next = key_now ? TONE_BASE : TONE_MID;
      end
      beep_timer_next = beep_count[7:0];
      if (beep_count > {1'b0, beep_limit}) begin
        beep_timer_next = 8'd0;
        drive_on_next   = 1'b0;
        if (key_now) begin
          key_pending_next = 1'b0;
        end else begin
          confirm_pending_next = 1'b0;
        end
      end
    end else if (tick_battery) begin
      source_next = SRC_BATTERY;
      if (alarm_phase == ALARM_PHASE_IDLE) begin
        drive_on_next    = 1'b1;
        tone_reg_next    = TONE_LOW;
        alarm_phase_next = alarm_phase + 3'd1;
        alarm_timer_next = 11'd0;
      end else begin
        alarm_timer_next = alarm_count[10:0];
        if (alarm_done) begin
          alarm_timer_next = 11'd0;
          alarm_phase_next = alarm_phase + 3'd1;
          if (alarm_phase == ALARM_PHASE_GAP_A || alarm_phase == ALARM_PHASE_GAP_B) begin
            drive_on_next = 1'b1;
            tone_reg_next = TONE_LOW;
          end else if (alarm_phase != ALARM_PHASE_PAUSE) begin
            drive_on_next = 1'b0;
          end
        end
      end
    end else if (notice_now) begin
      source_next = SRC_NOTICE;
      if (notice_phase == NOTICE_PHASE_IDLE) begin
        drive_on_next     = 1'b1;
        tone_reg_next     = TONE_MID;
        notice_timer_next = 8'd0;
        notice_phase_next = notice_phase + 3'd1;
      end else if (notice_phase <= NOTICE_PHASE_LAST) begin
        notice_timer_next = notice_count[7:0];
        if (notice_count >= {1'b0, notice_ticks}) begin
          notice_timer_next = 8'd0;
          if (notice_phase[0]) begin
            drive_on_next = 1'b0;
          end else begin
            drive_on_next = 1'b1;
            tone_reg_next = TONE_MID;
          end
          if (notice_phase == NOTICE_PHASE_LAST) begin
            notice_phase_next   = NOTICE_PHASE_IDLE;
            notice_pending_next = 1'b0;
          end else begin
            notice_phase_next = notice_phase + 3'd1;
          end
        end
      end
    end else begin
      drive_on_next    = 1'b0;
      beep_timer_next  = 8'd0;
      alarm_timer_next = 11'd0;
      alarm_phase_next = ALARM_PHASE_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_pending     <= 1'b0;
      confirm_pending <= 1'b0;
      notice_pending  <= 1'b0;
      beep_timer      <= 8'd0;
      alarm_phase     <= ALARM_PHASE_IDLE;
      alarm_timer     <= 11'd0;
      notice_phase    <= NOTICE_PHASE_IDLE;
      notice_timer    <= 8'd0;
      drive_on        <= 1'b0;
      tone_reg        <= TONE_BASE;
    end else if (advance) begin
      key_pending     <= key_pending_next;
      confirm_pending <= confirm_pending_next;
      notice_pending  <= notice_pending_next;
      beep_timer      <= beep_timer_next;
      alarm_phase     <= alarm_phase_next;
      alarm_timer     <= alarm_timer_next;
      notice_phase    <= notice_phase_next;
      notice_timer    <= notice_timer_next;
      drive_on        <= drive_on_next;
      tone_reg        <= tone_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      buzzer_on     <= drive_on_next;
      tone_select   <= tone_reg_next;
      active_source <= source_next;
    end
  end

endmodule

`default_nettype wire
